FILE: hw/rtl/vmc_pkg.sv
// ----------------------------------------------------------------------------
// vmc_pkg
// Shared widths, codes and request/result types of the vertex movement clamp.
// ----------------------------------------------------------------------------
package vmc_pkg;

  localparam int POS_W = 24;
  localparam int DLT_W = 25;
  localparam int STEP_W = 23;
  localparam int CLS_W = 2;
  localparam int VTX_W = 16;

  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_CLAMP = 1'b1;

  localparam logic [CLS_W-1:0] CLS_FREE = 2'd0;
  localparam logic [CLS_W-1:0] CLS_CONSTRAINED = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LOCKED = 2'd2;

  localparam logic [STEP_W-1:0] MAX_STEP_RST = 23'd256;

  localparam logic signed [POS_W:0] POS_MAX = 25'sd8388607;
  localparam logic signed [POS_W:0] POS_MIN = -25'sd8388608;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t old_x;
    pos_t old_y;
    pos_t old_z;
    pos_t new_x;
    pos_t new_y;
    pos_t new_z;
  } job_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
    logic allowed;
  } result_t;

endpackage

FILE: hw/rtl/vmc_req_if.sv
// ----------------------------------------------------------------------------
// vmc_req_if
// Request channel: a class write or a clamp request with both positions.
// ----------------------------------------------------------------------------
interface vmc_req_if import vmc_pkg::*; ();

  logic valid;
  logic ready;
  logic cmd;
  logic [VTX_W-1:0] vertex;
  logic [CLS_W-1:0] vertex_class;
  pos_t old_x;
  pos_t old_y;
  pos_t old_z;
  pos_t new_x;
  pos_t new_y;
  pos_t new_z;

  modport source (
    output valid, cmd, vertex, vertex_class, old_x, old_y, old_z, new_x, new_y, new_z,
    input ready
  );

  modport sink (
    input valid, cmd, vertex, vertex_class, old_x, old_y, old_z, new_x, new_y, new_z,
    output ready
  );

endinterface

FILE: hw/rtl/vmc_rsp_if.sv
// ----------------------------------------------------------------------------
// vmc_rsp_if
// Result channel: the resulting position and the allowed flag.
// ----------------------------------------------------------------------------
interface vmc_rsp_if import vmc_pkg::*; ();

  logic valid;
  logic ready;
  pos_t out_x;
  pos_t out_y;
  pos_t out_z;
  logic allowed;

  modport source (
    output valid, out_x, out_y, out_z, allowed,
    input ready
  );

  modport sink (
    input valid, out_x, out_y, out_z, allowed,
    output ready
  );

endinterface

FILE: hw/rtl/vmc_class_mem.sv
// ----------------------------------------------------------------------------
// vmc_class_mem
// Single-port class table with registered read data and a clearing pass
// that writes every entry to free after reset.
// ----------------------------------------------------------------------------
module vmc_class_mem import vmc_pkg::*; #(
  parameter int VERTEX_COUNT = 65536,
  parameter int AW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [CLS_W-1:0] wdata,
  output logic [CLS_W-1:0] rd_data,
  output logic             busy
);

  logic [CLS_W-1:0] mem [VERTEX_COUNT];
  logic [CLS_W-1:0] rd_data_r;
  logic             clr_r;
  logic [AW-1:0]    clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      if (clr_addr_r == AW'(VERTEX_COUNT - 1)) begin
        clr_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= CLS_FREE;
    end else if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy = clr_r;

endmodule

FILE: hw/rtl/vmc_clamp_engine.sv
// ----------------------------------------------------------------------------
// vmc_clamp_engine
// Sequential datapath for one clamp request: squares, bitwise square root,
// per-axis scaling by a restoring divider and saturated add-back.
// ----------------------------------------------------------------------------
module vmc_clamp_engine import vmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  job_t              job,
  input  logic [CLS_W-1:0]  cls,
  input  logic [STEP_W-1:0] max_step,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [4:0] SQRT_LAST = 5'd24;
  localparam logic [4:0] DIV_LAST = 5'd23;

  logic [2:0]       st_r;
  logic [2:0]       st_nxt;
  logic [4:0]       cnt_r;
  logic [1:0]       axis_r;
  logic [DLT_W-1:0] dmag_r [3];
  logic [2:0]       dneg_r;
  pos_t             old_r [3];
  pos_t             new_r [3];
  pos_t             res_r [3];
  logic             allowed_r;
  logic [48:0]      prod_r;
  logic [49:0]      sum_r;
  logic [49:0]      n_r;
  logic [27:0]      rem_r;
  logic [24:0]      root_r;
  logic [23:0]      q_r;

  logic signed [DLT_W-1:0] d_in [3];
  logic [DLT_W-1:0]        dmag_in [3];
  logic [DLT_W-1:0]        dmag_sel;
  logic [49:0]             sq_full;
  logic [47:0]             scl_full;
  logic [27:0]             rem_sh;
  logic [27:0]             trial;
  logic                    sq_ge;
  logic [25:0]             drem_sh;
  logic                    dv_ge;
  logic signed [DLT_W-1:0] q_signed;
  logic signed [POS_W+1:0] add_sum;
  pos_t                    add_sat;
  logic                    clamp_hit;

  assign d_in[0] = {job.new_x[POS_W-1], job.new_x} - {job.old_x[POS_W-1], job.old_x};
  assign d_in[1] = {job.new_y[POS_W-1], job.new_y} - {job.old_y[POS_W-1], job.old_y};
  assign d_in[2] = {job.new_z[POS_W-1], job.new_z} - {job.old_z[POS_W-1], job.old_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag_in[i] = d_in[i][DLT_W-1] ? DLT_W'(-d_in[i]) : DLT_W'(d_in[i]);
    end
  end

  assign dmag_sel = dmag_r[axis_r];
  assign sq_full = dmag_sel * dmag_sel;
  assign scl_full = 48'(dmag_sel * max_step);

  assign rem_sh = {rem_r[25:0], n_r[49:48]};
  assign trial = {1'b0, root_r, 2'b01};
  assign sq_ge = rem_sh >= trial;

  assign drem_sh = {rem_r[24:0], n_r[49]};
  assign dv_ge = drem_sh >= {1'b0, root_r};

  assign q_signed = dneg_r[axis_r] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign add_sum = {{2{old_r[axis_r][POS_W-1]}}, old_r[axis_r]}
                 + {q_signed[DLT_W-1], q_signed};

  always_comb begin
    if (add_sum > $signed({POS_MAX[POS_W], POS_MAX})) begin
      add_sat = POS_MAX[POS_W-1:0];
    end else if (add_sum < $signed({POS_MIN[POS_W], POS_MIN})) begin
      add_sat = POS_MIN[POS_W-1:0];
    end else begin
      add_sat = add_sum[POS_W-1:0];
    end
  end

  assign clamp_hit = root_r > {2'b00, max_step};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = (cls == CLS_CONSTRAINED) ? S_SQ : S_DONE;
        end
      end
      S_SQ: begin
        if (axis_r == 2'd3) begin
          st_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        st_nxt = clamp_hit ? S_MUL : S_DONE;
      end
      S_MUL: begin
        st_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          st_nxt = S_ADD;
        end
      end
      S_ADD: begin
        st_nxt = (axis_r == 2'd2) ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            dmag_r[i] <= dmag_in[i];
            dneg_r[i] <= d_in[i][DLT_W-1];
          end
          old_r[0] <= job.old_x;
          old_r[1] <= job.old_y;
          old_r[2] <= job.old_z;
          new_r[0] <= job.new_x;
          new_r[1] <= job.new_y;
          new_r[2] <= job.new_z;
          axis_r <= 2'd0;
          sum_r <= '0;
          if (cls == CLS_LOCKED) begin
            res_r[0] <= job.old_x;
            res_r[1] <= job.old_y;
            res_r[2] <= job.old_z;
            allowed_r <= 1'b0;
          end else begin
            res_r[0] <= job.new_x;
            res_r[1] <= job.new_y;
            res_r[2] <= job.new_z;
            allowed_r <= 1'b1;
          end
        end
      end
      S_SQ: begin
        if (axis_r != 2'd3) begin
          prod_r <= sq_full[48:0];
        end
        if (axis_r != 2'd0) begin
          sum_r <= sum_r + 50'(prod_r);
        end
        n_r <= sum_r + 50'(prod_r);
        rem_r <= '0;
        root_r <= '0;
        cnt_r <= '0;
        axis_r <= axis_r + 1'b1;
      end
      S_SQRT: begin
        rem_r <= sq_ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[23:0], sq_ge};
        n_r <= {n_r[47:0], 2'b00};
        cnt_r <= cnt_r + 1'b1;
      end
      S_CMP: begin
        axis_r <= 2'd0;
        if (clamp_hit) begin
          allowed_r <= 1'b0;
        end else begin
          res_r[0] <= new_r[0];
          res_r[1] <= new_r[1];
          res_r[2] <= new_r[2];
          allowed_r <= 1'b1;
        end
      end
      S_MUL: begin
        rem_r <= {4'b0000, scl_full[47:24]};
        n_r <= {scl_full[23:0], 26'd0};
        q_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= dv_ge ? 28'(drem_sh - {1'b0, root_r}) : 28'(drem_sh);
        q_r <= {q_r[22:0], dv_ge};
        n_r <= {n_r[48:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      S_ADD: begin
        res_r[axis_r] <= add_sat;
        axis_r <= axis_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_valid = (st_r == S_DONE);
  assign res.x = res_r[0];
  assign res.y = res_r[1];
  assign res.z = res_r[2];
  assign res.allowed = allowed_r;

endmodule

FILE: hw/rtl/vertex_movement_clamp_unit.sv
// ----------------------------------------------------------------------------
// vertex_movement_clamp_unit
// Per-vertex movement clamp with a class table held in on-chip memory.
// ----------------------------------------------------------------------------
// A class write request gives no result. A clamp request reads the class
// table (a registered read) and is then worked by a single sequential engine:
// free and locked vertices pass straight through; a constrained vertex is
// worked by squares, a 25-step square root and, when clamped, three 24-step
// divisions. One clamp request is in flight at a time; a finished result
// waits in the output register while the next request is taken. After reset
// the table is cleared to free, one entry after another, during which no
// request is accepted.
module vertex_movement_clamp_unit import vmc_pkg::*; #(
  parameter int VERTEX_COUNT = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata,
  vmc_req_if.sink           in_ch,
  vmc_rsp_if.source         out_ch
);

  localparam int AW = $clog2(VERTEX_COUNT);

  logic [STEP_W-1:0] max_step_r;
  logic              busy_r;
  logic              start_r;
  logic              rng_r;
  job_t              job_r;
  logic              out_valid_r;
  result_t           out_res_r;

  logic              mem_busy;
  logic [CLS_W-1:0]  mem_rd_data;
  logic              acc;
  logic [31:0]       vx32;
  logic              in_rng;
  logic              mem_we;
  logic              mem_re;
  logic [CLS_W-1:0]  cls_sel;
  logic              eng_valid;
  logic              eng_take;
  result_t           eng_res;

  assign in_ch.ready = !mem_busy && !busy_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign vx32 = 32'(in_ch.vertex);
  assign in_rng = vx32 < 32'(VERTEX_COUNT);
  assign mem_we = acc && (in_ch.cmd == CMD_SET) && in_rng;
  assign mem_re = acc && (in_ch.cmd == CMD_CLAMP) && in_rng;
  assign cls_sel = rng_r ? mem_rd_data : CLS_FREE;
  assign eng_take = eng_valid && (!out_valid_r || out_ch.ready);

  vmc_class_mem #(
    .VERTEX_COUNT(VERTEX_COUNT),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .rst_n(rst_n),
    .we(mem_we),
    .re(mem_re),
    .addr(vx32[AW-1:0]),
    .wdata(in_ch.vertex_class),
    .rd_data(mem_rd_data),
    .busy(mem_busy)
  );

  vmc_clamp_engine u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .start(start_r),
    .job(job_r),
    .cls(cls_sel),
    .max_step(max_step_r),
    .res_valid(eng_valid),
    .res_ready(eng_take),
    .res(eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r <= MAX_STEP_RST;
    end else if (cfg_we) begin
      max_step_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (acc && (in_ch.cmd == CMD_CLAMP)) begin
        busy_r <= 1'b1;
        start_r <= 1'b1;
      end else if (eng_take) begin
        busy_r <= 1'b0;
      end
      if (eng_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rng_r <= in_rng;
      job_r.old_x <= in_ch.old_x;
      job_r.old_y <= in_ch.old_y;
      job_r.old_z <= in_ch.old_z;
      job_r.new_x <= in_ch.new_x;
      job_r.new_y <= in_ch.new_y;
      job_r.new_z <= in_ch.new_z;
    end
    if (eng_take) begin
      out_res_r <= eng_res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_x = out_res_r.x;
  assign out_ch.out_y = out_res_r.y;
  assign out_ch.out_z = out_res_r.z;
  assign out_ch.allowed = out_res_r.allowed;

endmodule

FILE: bench/tb_vertex_movement_clamp_unit.sv
// ----------------------------------------------------------------------------
// tb_vertex_movement_clamp_unit
// Self-checking bench for the vertex movement clamp. Class writes and clamp
// requests are driven through the request channel. A scoreboard keeps its own
// class table and max_step and predicts every clamp result, which is then
// compared field by field with what the block returns. The run covers directed
// corner cases, then random phases under several max_step settings and
// several patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_vertex_movement_clamp_unit;
  import vmc_pkg::*;

  localparam int VERTEX_COUNT = 65536;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 150;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [CLS_W-1:0] CLS_SPARE = 2'd3;
  localparam pos_t P_MAX = 24'sh7FFFFF;
  localparam pos_t P_MIN = 24'sh800000;

  typedef struct packed {
    logic cmd;
    logic [VTX_W-1:0] vertex;
    logic [CLS_W-1:0] vertex_class;
    job_t job;
  } move_req_t;

  class move_scoreboard #(int DEPTH = 65536);
    logic [CLS_W-1:0] vertex_kind [DEPTH];
    logic [STEP_W-1:0] max_step;
    result_t expected_q[$];
    int mismatches;

    function new();
      foreach (vertex_kind[i]) vertex_kind[i] = CLS_FREE;
      max_step = MAX_STEP_RST;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function pos_t saturate(longint v);
      if (v > longint'(POS_MAX)) return pos_t'(POS_MAX);
      if (v < longint'(POS_MIN)) return pos_t'(POS_MIN);
      return pos_t'(v);
    endfunction

    function longint floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned cand;
      int b;
      root = 0;
      for (b = 25; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= n) root = cand;
      end
      return longint'(root);
    endfunction

    function result_t predict_move(move_req_t r);
      logic [CLS_W-1:0] kind;
      longint oldp[3];
      longint newp[3];
      longint d[3];
      longint unsigned sq;
      longint len;
      longint ms;
      pos_t res[3];
      result_t out;
      int i;
      kind = CLS_FREE;
      if (int'(r.vertex) < DEPTH) kind = vertex_kind[r.vertex];
      oldp[0] = r.job.old_x;
      oldp[1] = r.job.old_y;
      oldp[2] = r.job.old_z;
      newp[0] = r.job.new_x;
      newp[1] = r.job.new_y;
      newp[2] = r.job.new_z;
      out.allowed = 1'b1;
      sq = 0;
      for (i = 0; i < 3; i++) begin
        res[i] = pos_t'(newp[i]);
        d[i] = newp[i] - oldp[i];
        sq += longint'(d[i] * d[i]);
      end
      if (kind == CLS_LOCKED) begin
        for (i = 0; i < 3; i++) res[i] = pos_t'(oldp[i]);
        out.allowed = 1'b0;
      end else if (kind == CLS_CONSTRAINED) begin
        len = floor_sqrt(sq);
        ms = longint'({41'd0, max_step});
        if (len > ms) begin
          for (i = 0; i < 3; i++) res[i] = saturate(oldp[i] + (d[i] * ms) / len);
          out.allowed = 1'b0;
        end
      end
      out.x = res[0];
      out.y = res[1];
      out.z = res[2];
      return out;
    endfunction

    function void note_request(move_req_t r);
      if (r.cmd == CMD_SET) begin
        if (int'(r.vertex) < DEPTH) vertex_kind[r.vertex] = r.vertex_class;
      end else begin
        expected_q.insert(expected_q.size(), predict_move(r));
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH: %s", msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result x=%0d y=%0d z=%0d allowed=%0b",
                         got.x, got.y, got.z, got.allowed));
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x) report($sformatf("out_x %0d, expected %0d", got.x, want.x));
      if (got.y !== want.y) report($sformatf("out_y %0d, expected %0d", got.y, want.y));
      if (got.z !== want.z) report($sformatf("out_z %0d, expected %0d", got.z, want.z));
      if (got.allowed !== want.allowed) begin
        report($sformatf("allowed %0b, expected %0b", got.allowed, want.allowed));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [STEP_W-1:0] cfg_wdata;

  vmc_req_if req_ch ();
  vmc_rsp_if rsp_ch ();

  vertex_movement_clamp_unit #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch)
  );

  move_scoreboard #(VERTEX_COUNT) sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_req;
  int cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(result_t'({rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.allowed}));
    end
  end

  // The receiver counts a requested hold-off in cycles on its own.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 72;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 72;
      end
      default: begin
        send_idle_pct = 30;
        recv_stall_pct = 30;
      end
    endcase
  endtask

  function automatic move_req_t class_req(input logic [VTX_W-1:0] vtx,
                                          input logic [CLS_W-1:0] kind);
    move_req_t r;
    r.cmd = CMD_SET;
    r.vertex = vtx;
    r.vertex_class = kind;
    r.job = job_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return r;
  endfunction

  function automatic move_req_t clamp_req(input logic [VTX_W-1:0] vtx,
                                          input pos_t ox, input pos_t oy, input pos_t oz,
                                          input pos_t nx, input pos_t ny, input pos_t nz);
    move_req_t r;
    r.cmd = CMD_CLAMP;
    r.vertex = vtx;
    r.vertex_class = CLS_W'($urandom_range(0, 3));
    r.job.old_x = ox;
    r.job.old_y = oy;
    r.job.old_z = oz;
    r.job.new_x = nx;
    r.job.new_y = ny;
    r.job.new_z = nz;
    return r;
  endfunction

  // Most requests hit a small pool of vertices at both ends of the table so
  // that class writes and clamps meet; deltas cluster around max_step.
  function automatic move_req_t random_request(input logic [STEP_W-1:0] ms);
    move_req_t r;
    logic [3:0] pick;
    logic [VTX_W-1:0] vtx;
    logic [CLS_W-1:0] kind;
    pos_t o[3];
    pos_t n[3];
    longint lim;
    longint d;
    int sel;
    int i;
    pick = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 4) == 0) vtx = VTX_W'($urandom);
    else vtx = pick[3] ? (16'hFFF8 | pick[2:0]) : {13'd0, pick[2:0]};
    if ($urandom_range(0, 9) < 3) begin
      sel = $urandom_range(0, 9);
      kind = (sel < 4) ? CLS_CONSTRAINED : (sel < 6) ? CLS_LOCKED :
             (sel < 8) ? CLS_FREE : CLS_SPARE;
      return class_req(vtx, kind);
    end
    lim = 2 * longint'({41'd0, ms}) + 2;
    sel = $urandom_range(0, 9);
    for (i = 0; i < 3; i++) begin
      o[i] = pos_t'($urandom);
      if (sel < 2) begin
        n[i] = pos_t'($urandom);
      end else if (sel < 8) begin
        d = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        n[i] = sb.saturate(longint'(o[i]) + d);
      end else if (sel == 8) begin
        n[i] = o[i];
      end else begin
        o[i] = $urandom_range(0, 1) ? P_MAX : P_MIN;
        n[i] = $urandom_range(0, 1) ? P_MAX : P_MIN;
      end
    end
    return clamp_req(vtx, o[0], o[1], o[2], n[0], n[1], n[2]);
  endfunction

  task automatic send_request(input move_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= r.cmd;
    req_ch.vertex <= r.vertex;
    req_ch.vertex_class <= r.vertex_class;
    req_ch.old_x <= r.job.old_x;
    req_ch.old_y <= r.job.old_y;
    req_ch.old_z <= r.job.old_z;
    req_ch.new_x <= r.job.new_x;
    req_ch.new_y <= r.job.new_y;
    req_ch.new_z <= r.job.new_z;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_step(input logic [STEP_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    sb.max_step = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [STEP_W-1:0] steps [PHASE_COUNT];
    int p;
    int k;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = MAX_STEP_RST;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_SET;
    req_ch.vertex = '0;
    req_ch.vertex_class = CLS_FREE;
    req_ch.old_x = '0;
    req_ch.old_y = '0;
    req_ch.old_z = '0;
    req_ch.new_x = '0;
    req_ch.new_y = '0;
    req_ch.new_z = '0;
    rsp_ch.ready = 1'b0;
    hold_off_req = 1'b0;
    sb = new();
    set_idling(0);
    steps[0] = 23'd0;
    steps[1] = 23'h7FFFFF;
    steps[2] = 23'd1;
    steps[3] = MAX_STEP_RST;
    steps[4] = STEP_W'($urandom_range(1, 4096));
    steps[5] = STEP_W'($urandom_range(0, 23'h7FFFFF));
    steps[6] = 23'h7FFFFF;
    steps[7] = STEP_W'($urandom_range(2, 65536));
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests run with max_step at its reset value.
    send_request(class_req(16'd0, CLS_CONSTRAINED));
    send_request(class_req(16'd1, CLS_LOCKED));
    send_request(class_req(16'hFFFF, CLS_SPARE));
    send_request(class_req(16'd2, CLS_FREE));
    send_request(class_req(16'd3, CLS_CONSTRAINED));
    send_request(clamp_req(16'd0, 0, 0, 0, 0, 0, 0));
    send_request(clamp_req(16'd0, 100, -50, 7, 356, -50, 7));
    send_request(clamp_req(16'd0, 0, 0, 0, 257, 0, 0));
    send_request(clamp_req(16'd0, -1000, 2000, -3000, -1300, 2400, -3000));
    send_request(clamp_req(16'd3, P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX));
    send_request(clamp_req(16'd3, P_MAX, P_MAX, P_MAX, P_MIN, P_MIN, P_MIN));
    send_request(clamp_req(16'd3, P_MAX, P_MIN, 0, P_MIN, P_MAX, 0));
    send_request(clamp_req(16'd1, P_MIN, P_MAX, P_MIN, P_MAX, P_MIN, P_MAX));
    send_request(clamp_req(16'hFFFF, P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX));
    send_request(clamp_req(16'd2, P_MAX, P_MAX, P_MAX, P_MIN, P_MIN, P_MIN));
    send_request(clamp_req(16'h1234, 1, 2, 3, 40000, -40000, 5));
    send_request(class_req(16'd1, CLS_FREE));
    send_request(clamp_req(16'd1, 0, 0, 0, P_MAX, P_MIN, P_MAX));
    send_request(class_req(16'd0, CLS_LOCKED));
    send_request(clamp_req(16'd0, 5, 6, 7, 8, 9, 10));
    send_request(class_req(16'hFFFF, CLS_CONSTRAINED));
    send_request(clamp_req(16'hFFFF, 0, 0, 0, 0, 0, P_MIN));
    req_ch.valid <= 1'b0;
    wait_drain();

    for (p = 0; p < PHASE_COUNT; p++) begin
      write_max_step(steps[p]);
      set_idling(p % 4);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Long receiver hold-off while requests keep coming.
        if (p == 0 && k == 40) hold_off_req = 1'b1;
        // Sender pauses until every pending clamp result is back.
        if (p == 2 && k == 125) begin
          req_ch.valid <= 1'b0;
          wait_drain();
        end
        send_request(random_request(steps[p]));
      end
      req_ch.valid <= 1'b0;
      wait_drain();
    end

    set_idling(0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vmc_pkg.sv
hw/rtl/vmc_req_if.sv
hw/rtl/vmc_rsp_if.sv
hw/rtl/vmc_class_mem.sv
hw/rtl/vmc_clamp_engine.sv
hw/rtl/vertex_movement_clamp_unit.sv
bench/tb_vertex_movement_clamp_unit.sv
